// ===== rtl/core/ssmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssmf_pkg
// Shared types and constants for the stereo soft-mute fader.
// ----------------------------------------------------------------------------
package ssmf_pkg;

	// fade rate is Q0.16 whatever the gain precision; threshold is Q1.16, in gain LSBs
	localparam int RATE_BITS      = 16;
	localparam int RATE_FRAC_BITS = 16;
	localparam int THR_BITS       = 17;
	localparam int CFG_DATA_BITS  = 17;
	localparam int CFG_IDX_BITS   = 1;

	localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd328;
	localparam logic [THR_BITS-1:0]  THR_RESET  = 17'd1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_RATE      = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_THRESHOLD = 1'b1;

	typedef enum logic [2:0] {
		MODE_UNMUTED = 3'd0,
		MODE_MUTED   = 3'd1,
		MODE_DOWN    = 3'd2,
		MODE_UP      = 3'd3,
		MODE_INITIAL = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_UPD,
		ST_MUL_L,
		ST_MUL_R,
		ST_FIN
	} seq_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssmf_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssmf_mul
// Shared signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ssmf_mul #(
	parameter int A_BITS = 24,
	parameter int B_BITS = 17
) (
	input  wire                          clk,
	input  wire                          en,
	input  wire logic signed [A_BITS-1:0] a,
	input  wire logic [B_BITS-1:0]        b,
	output logic signed [A_BITS+B_BITS:0] prod_q
);

	logic signed [A_BITS+B_BITS:0] prod;

	assign prod = (A_BITS + B_BITS + 1)'(a) * (A_BITS + B_BITS + 1)'($signed({1'b0, b}));

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/stereo_soft_mute_fader.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_soft_mute_fader
// Stereo soft mute with exponential gain ramps on mute edges.
// ----------------------------------------------------------------------------
// One item is taken at a time. After its transfer it runs through ST_MUL_L,
// ST_MUL_R and ST_FIN before the next transfer; a fade step puts ST_STEP and
// ST_UPD ahead of them. All products go through one shared multiplier in
// turn: fade rate times distance, then left times gain, then right times
// gain. A finished result sits in the output register, so the next item may
// be taken while it waits; the block stalls only if a second result is ready
// before the first has gone out.
module stereo_soft_mute_fader #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  wire clk,
	input  wire arst_n,
	// config write port
	input  wire                                         cfg_we,
	input  wire logic [ssmf_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
	input  wire logic [ssmf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	// input stream
	input  wire                                         s_tvalid,
	output logic                                        s_tready,
	// mute, left_in, right_in
	input  wire logic [((2*SAMPLE_BITS+1+7)/8)*8-1:0]   s_tdata,
	// output stream
	output logic                                        m_tvalid,
	input  wire                                         m_tready,
	// left_out, right_out, gain_now, mode_now
	output logic [((2*SAMPLE_BITS+GAIN_FRAC_BITS+4+7)/8)*8-1:0] m_tdata
);

	localparam int SB = SAMPLE_BITS;
	localparam int GF = GAIN_FRAC_BITS;
	localparam int GB = GF + 1;
	localparam int OW = ((2*SAMPLE_BITS+GAIN_FRAC_BITS+4+7)/8)*8;
	localparam int MA = (SB > ssmf_pkg::RATE_BITS + 1) ? SB : ssmf_pkg::RATE_BITS + 1;
	localparam int PW = MA + GB + 1;
	localparam int CW = (GB > ssmf_pkg::THR_BITS) ? GB : ssmf_pkg::THR_BITS;

	localparam logic [GB-1:0] GAIN_ONE = {1'b1, {GF{1'b0}}};
	localparam logic signed [PW-1:0] SMAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [PW-1:0] SMIN = ~SMAX;
	localparam logic signed [PW-1:0] RND  = {{(PW-GF){1'b0}}, {GF{1'b1}}};

	// input fields
	logic                 in_mute;
	logic signed [SB-1:0] in_left;
	logic signed [SB-1:0] in_right;

	assign in_mute  = s_tdata[0];
	assign in_left  = s_tdata[SB:1];
	assign in_right = s_tdata[2*SB:SB+1];

	// state
	ssmf_pkg::seq_state_t state_q, state_d;
	ssmf_pkg::mode_t      mode_q, mode_e, mode_n;
	logic [GB-1:0]        gain_q, gain_e, gain_n;
	logic                 known_q, last_q;
	logic [ssmf_pkg::RATE_BITS-1:0] rate_q;
	logic [ssmf_pkg::THR_BITS-1:0]  thr_q;
	logic [GB-1:0]        dist_q, dist_n;
	logic                 up_q, up_n;
	logic                 need_step;
	logic signed [SB-1:0] left_in_q, right_in_q, left_res_q;

	// output register
	logic                 m_tvalid_q;
	logic signed [SB-1:0] left_out_q, right_out_q;
	logic [GB-1:0]        gain_out_q;
	ssmf_pkg::mode_t      mode_out_q;

	// sequencer strobes
	logic accept, out_load, mul_en;
	logic signed [MA-1:0] mul_a;
	logic [GB-1:0]        mul_b;
	logic signed [PW-1:0] prod_q;

	// mute edges first, then the mode update
	always_comb begin
		mode_e    = mode_q;
		gain_e    = gain_q;
		if (known_q) begin
			if (in_mute && !last_q) begin
				mode_e = ssmf_pkg::MODE_DOWN;
				gain_e = GAIN_ONE;
			end
			if (!in_mute && last_q) begin
				mode_e = ssmf_pkg::MODE_UP;
				gain_e = '0;
			end
		end
		mode_n    = mode_e;
		gain_n    = gain_e;
		need_step = 1'b0;
		dist_n    = gain_e;
		up_n      = 1'b0;
		case (mode_e)
			ssmf_pkg::MODE_INITIAL: begin
				mode_n = in_mute ? ssmf_pkg::MODE_MUTED : ssmf_pkg::MODE_UNMUTED;
			end
			ssmf_pkg::MODE_MUTED: begin
				gain_n = '0;
			end
			ssmf_pkg::MODE_UNMUTED: begin
				gain_n = GAIN_ONE;
			end
			ssmf_pkg::MODE_DOWN: begin
				dist_n = gain_e;
				if (CW'(dist_n) <= CW'(thr_q)) begin
					mode_n = ssmf_pkg::MODE_MUTED;
					gain_n = '0;
				end else begin
					need_step = 1'b1;
				end
			end
			ssmf_pkg::MODE_UP: begin
				dist_n = GAIN_ONE - gain_e;
				up_n   = 1'b1;
				if (CW'(dist_n) <= CW'(thr_q)) begin
					mode_n = ssmf_pkg::MODE_UNMUTED;
					gain_n = GAIN_ONE;
				end else begin
					need_step = 1'b1;
				end
			end
			default: begin
				mode_n = ssmf_pkg::MODE_INITIAL;
			end
		endcase
	end

	// fade step from rate * distance, at least one lsb
	logic [GB-1:0] step_raw, step;
	assign step_raw = prod_q[ssmf_pkg::RATE_FRAC_BITS +: GB];
	assign step     = (step_raw == '0) ? GB'(1) : step_raw;

	// truncate toward zero, then saturate to the sample range
	logic signed [PW-1:0] adj, shr;
	logic signed [SB-1:0] sat;
	always_comb begin
		adj = prod_q + (prod_q[PW-1] ? RND : '0);
		shr = adj >>> GF;
		if (shr > SMAX) begin
			sat = SMAX[SB-1:0];
		end else if (shr < SMIN) begin
			sat = SMIN[SB-1:0];
		end else begin
			sat = shr[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		out_load = 1'b0;
		mul_en   = 1'b0;
		mul_a    = MA'(left_in_q);
		mul_b    = gain_q;
		case (state_q)
			ssmf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept  = 1'b1;
					state_d = need_step ? ssmf_pkg::ST_STEP : ssmf_pkg::ST_MUL_L;
				end
			end
			ssmf_pkg::ST_STEP: begin
				mul_en  = 1'b1;
				mul_a   = MA'($signed({1'b0, rate_q}));
				mul_b   = dist_q;
				state_d = ssmf_pkg::ST_UPD;
			end
			ssmf_pkg::ST_UPD: begin
				state_d = ssmf_pkg::ST_MUL_L;
			end
			ssmf_pkg::ST_MUL_L: begin
				mul_en  = 1'b1;
				state_d = ssmf_pkg::ST_MUL_R;
			end
			ssmf_pkg::ST_MUL_R: begin
				mul_en  = 1'b1;
				mul_a   = MA'(right_in_q);
				state_d = ssmf_pkg::ST_FIN;
			end
			ssmf_pkg::ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ssmf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ssmf_pkg::ST_IDLE;
			end
		endcase
	end

	ssmf_mul #(
		.A_BITS(MA),
		.B_BITS(GB)
	) u_mul (
		.clk   (clk),
		.en    (mul_en),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	// control and fader state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ssmf_pkg::MODE_INITIAL;
			gain_q     <= GAIN_ONE;
			known_q    <= 1'b0;
			last_q     <= 1'b0;
			rate_q     <= ssmf_pkg::RATE_RESET;
			thr_q      <= ssmf_pkg::THR_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					ssmf_pkg::CFG_FADE_RATE: begin
						rate_q <= cfg_data[ssmf_pkg::RATE_BITS-1:0];
					end
					ssmf_pkg::CFG_NEAR_THRESHOLD: begin
						thr_q <= cfg_data[ssmf_pkg::THR_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				known_q <= 1'b1;
				last_q  <= in_mute;
				mode_q  <= mode_n;
				gain_q  <= gain_n;
			end
			if (state_q == ssmf_pkg::ST_UPD) begin
				gain_q <= up_q ? gain_q + step : gain_q - step;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			left_in_q  <= in_left;
			right_in_q <= in_right;
			dist_q     <= dist_n;
			up_q       <= up_n;
		end
		if (state_q == ssmf_pkg::ST_MUL_R) begin
			left_res_q <= sat;
		end
		if (out_load) begin
			left_out_q  <= left_res_q;
			right_out_q <= sat;
			gain_out_q  <= gain_q;
			mode_out_q  <= mode_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OW'({mode_out_q, gain_out_q, right_out_q, left_out_q});

endmodule
`default_nettype wire

// ===== rtl/core/ssmf_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssmf_chk
// Port-level checks for the stereo soft-mute fader, bound to the top level.
// ----------------------------------------------------------------------------
module ssmf_chk #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 16
) (
	input wire clk,
	input wire arst_n,
	input wire s_tvalid,
	input wire s_tready,
	input wire m_tvalid,
	input wire m_tready,
	input wire logic [((2*SAMPLE_BITS+GAIN_FRAC_BITS+4+7)/8)*8-1:0] m_tdata
);

	localparam int GB = GAIN_FRAC_BITS + 1;

	logic [GB-1:0] gain_now;
	assign gain_now = m_tdata[2*SAMPLE_BITS +: GB];

	// one item at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in work");

	// a result needs the multiplier passes before it shows
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
		else $error("result appeared too soon after input transfer");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (gain_now <= {1'b1, {GAIN_FRAC_BITS{1'b0}}}))
		else $error("gain above unity");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output changed");

endmodule

bind stereo_soft_mute_fader ssmf_chk #(
	.SAMPLE_BITS   (SAMPLE_BITS),
	.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
) u_ssmf_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

// ===== verif/tb_stereo_soft_mute_fader.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_stereo_soft_mute_fader
// Self-checking bench for the soft-mute fader. A directed table covers the
// first sample after reset, sample extremes, snap at equal distance, one-LSB
// steps and huge thresholds. Random mute runs over several register settings
// follow, with random stalls on both sides and one long output hold-off.
// Outputs are checked against an in-bench gain/mode tracker or a table row.
// ----------------------------------------------------------------------------
module tb_stereo_soft_mute_fader;

	localparam int SB        = 24;
	localparam int GF        = 16;
	localparam int IN_W      = ((2*SB+1+7)/8)*8;
	localparam int OUT_W     = ((2*SB+GF+4+7)/8)*8;
	localparam longint UNITY = longint'(1) << GF;
	localparam longint S_MAX = (longint'(1) << (SB-1)) - 1;
	localparam longint S_MIN = -(longint'(1) << (SB-1));
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 235;

	typedef struct {
		logic [SB-1:0]   left;
		logic [SB-1:0]   right;
		logic [GF:0]     gain;
		ssmf_pkg::mode_t mode;
	} mix_t;

	typedef struct packed {
		int              rate;
		int              thr;
		bit              mute;
		int              left;
		int              right;
		bit              known;
		int              w_left;
		int              w_right;
		int              w_gain;
		ssmf_pkg::mode_t w_mode;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ssmf_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [ssmf_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;   // mute, left_in, right_in
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // left_out, right_out, gain_now, mode_now

	// tracked copy of the block
	int              rate_q = ssmf_pkg::RATE_RESET;
	int              thr_q = ssmf_pkg::THR_RESET;
	ssmf_pkg::mode_t mode_q = ssmf_pkg::MODE_INITIAL;
	longint          gain_q = UNITY;
	bit              level_seen = 1'b0;
	bit              prev_mute = 1'b0;

	mix_t mix_due[$];
	int errors = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int fades_done = 0;
	int settings_used = 1;
	int cycles = 0;
	bit steady_run = 1'b0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	probe_t probe_tab [24] = '{
		// reset settings: first sample passes at unity even when muted
		'{328, 1, 1'b1, 8388607, -8388608, 1'b1, 8388607, -8388608, 65536,
			ssmf_pkg::MODE_MUTED},
		'{328, 1, 1'b1, 8388607, -8388608, 1'b1, 0, 0, 0, ssmf_pkg::MODE_MUTED},
		'{328, 1, 1'b1, -1, 1, 1'b1, 0, 0, 0, ssmf_pkg::MODE_MUTED},
		'{328, 1, 1'b0, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{328, 1, 1'b0, -1, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{328, 1, 1'b1, 8388607, 1, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{328, 1, 1'b0, -8388608, 8388607, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		// near-full rate, zero threshold: last steps are one LSB, snap at zero
		'{65535, 0, 1'b0, 123456, -654321, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 0, 1'b0, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 0, 1'b0, -1, 1, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 0, 1'b0, 8388607, -8388608, 1'b1, 8388607, -8388608, 65536,
			ssmf_pkg::MODE_UNMUTED},
		'{65535, 0, 1'b1, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 0, 1'b1, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 0, 1'b1, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 0, 1'b1, 8388607, -8388608, 1'b1, 0, 0, 0, ssmf_pkg::MODE_MUTED},
		// threshold at unity: every fade ends on its first sample
		'{1, 65536, 1'b0, 8388607, -8388608, 1'b1, 8388607, -8388608, 65536,
			ssmf_pkg::MODE_UNMUTED},
		'{1, 65536, 1'b1, 8388607, -8388608, 1'b1, 0, 0, 0, ssmf_pkg::MODE_MUTED},
		// slowest rate: step truncates to zero and is raised to one LSB
		'{1, 0, 1'b0, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{1, 0, 1'b0, 8388607, -1, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{1, 0, 1'b1, -8388608, 8388607, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{1, 0, 1'b1, -3, 3, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 65535, 1'b1, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 65535, 1'b0, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL},
		'{65535, 65535, 1'b0, 8388607, -8388608, 1'b0, 0, 0, 0, ssmf_pkg::MODE_INITIAL}
	};

	stereo_soft_mute_fader #(
		.SAMPLE_BITS(SB),
		.GAIN_FRAC_BITS(GF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint ramp_step(longint span);
		longint st;
		st = (longint'(rate_q) * span) >>> 16;
		if (st == 0) begin
			st = 1;
		end
		return st;
	endfunction

	// product truncated toward zero, then clamped to the sample range
	function automatic logic [SB-1:0] apply_gain(logic signed [SB-1:0] s, longint g);
		longint p;
		longint q;
		p = longint'(s) * g;
		if (p < 0) begin
			q = -((-p) >>> GF);
		end else begin
			q = p >>> GF;
		end
		if (q > S_MAX) q = S_MAX;
		if (q < S_MIN) q = S_MIN;
		return q[SB-1:0];
	endfunction

	function automatic mix_t fader_next(bit mute, logic signed [SB-1:0] l,
		logic signed [SB-1:0] r);
		mix_t o;
		longint span;
		if (!level_seen) begin
			level_seen = 1'b1;
		end else begin
			if (mute && !prev_mute) begin
				mode_q = ssmf_pkg::MODE_DOWN;
				gain_q = UNITY;
			end
			if (!mute && prev_mute) begin
				mode_q = ssmf_pkg::MODE_UP;
				gain_q = 0;
			end
		end
		prev_mute = mute;
		case (mode_q)
			ssmf_pkg::MODE_INITIAL: begin
				mode_q = mute ? ssmf_pkg::MODE_MUTED : ssmf_pkg::MODE_UNMUTED;
			end
			ssmf_pkg::MODE_MUTED:   gain_q = 0;
			ssmf_pkg::MODE_UNMUTED: gain_q = UNITY;
			ssmf_pkg::MODE_DOWN: begin
				span = gain_q < 0 ? -gain_q : gain_q;
				if (span <= longint'(thr_q)) begin
					mode_q = ssmf_pkg::MODE_MUTED;
					gain_q = 0;
					fades_done++;
				end else begin
					gain_q = gain_q - ramp_step(span);
				end
			end
			ssmf_pkg::MODE_UP: begin
				span = UNITY - gain_q;
				if (span < 0) span = -span;
				if (span <= longint'(thr_q)) begin
					mode_q = ssmf_pkg::MODE_UNMUTED;
					gain_q = UNITY;
					fades_done++;
				end else begin
					gain_q = gain_q + ramp_step(span);
				end
			end
			default: mode_q = ssmf_pkg::MODE_INITIAL;
		endcase
		if (gain_q < 0) gain_q = 0;
		if (gain_q > UNITY) gain_q = UNITY;
		o.left = apply_gain(l, gain_q);
		o.right = apply_gain(r, gain_q);
		o.gain = gain_q[GF:0];
		o.mode = mode_q;
		return o;
	endfunction

	function automatic logic [SB-1:0] pick_sample();
		logic [SB-1:0] v;
		case ($urandom_range(15))
			0: v = S_MAX[SB-1:0];
			1: v = S_MIN[SB-1:0];
			2: v = '0;
			3: v = '1;
			4: v = SB'($urandom_range(7));
			default: v = SB'($urandom());
		endcase
		return v;
	endfunction

	// pushes the tracked result unless a literal one is given
	task automatic offer_sample(bit mute, logic [SB-1:0] l, logic [SB-1:0] r,
		bit known, mix_t literal);
		mix_t want;
		while (!steady_run && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-2*SB-1){1'b0}}, r, l, mute};
		do @(posedge clk); while (s_tready !== 1'b1);
		want = fader_next(mute, l, r);
		mix_due.push_back(known ? literal : want);
		samples_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (mix_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_setup(int rate, int thr);
		cfg_idx <= ssmf_pkg::CFG_FADE_RATE;
		cfg_data <= ssmf_pkg::CFG_DATA_BITS'(rate);
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_idx <= ssmf_pkg::CFG_NEAR_THRESHOLD;
		cfg_data <= ssmf_pkg::CFG_DATA_BITS'(thr);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		rate_q = rate;
		thr_q = thr;
		settings_used++;
	endtask

	// output side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady_run || $urandom_range(99) >= 11;
		end
	end

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (mix_due.size() == 0) begin
				$error("output transfer with nothing pending: %h", m_tdata);
				errors++;
			end else begin
				mix_t w;
				w = mix_due.pop_front();
				check_field("left_out", $signed(w.left), $signed(m_tdata[SB-1:0]));
				check_field("right_out", $signed(w.right), $signed(m_tdata[2*SB-1:SB]));
				check_field("gain_now", w.gain, m_tdata[2*SB+GF:2*SB]);
				check_field("mode_now", w.mode, m_tdata[2*SB+GF+3:2*SB+GF+1]);
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_stereo_soft_mute_fader: errors");
			$finish;
		end
	end

	initial begin
		mix_t literal;
		int rate;
		int thr;
		int run;
		int sent;
		bit lvl;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_tab[i]) begin
			if (probe_tab[i].rate != rate_q || probe_tab[i].thr != thr_q) begin
				settle();
				apply_setup(probe_tab[i].rate, probe_tab[i].thr);
			end
			literal.left = probe_tab[i].w_left[SB-1:0];
			literal.right = probe_tab[i].w_right[SB-1:0];
			literal.gain = probe_tab[i].w_gain[GF:0];
			literal.mode = probe_tab[i].w_mode;
			offer_sample(probe_tab[i].mute, probe_tab[i].left[SB-1:0],
				probe_tab[i].right[SB-1:0], probe_tab[i].known, literal);
		end

		lvl = prev_mute;
		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: begin rate = 65535; thr = 0; end
				1: begin rate = 4096; thr = 16; end
				2: begin rate = 1; thr = 65536; end
				3: begin rate = $urandom_range(1, 65535); thr = $urandom_range(0, 65536); end
				4: begin rate = $urandom_range(2000, 65535); thr = $urandom_range(0, 300); end
				default: begin rate = ssmf_pkg::RATE_RESET; thr = ssmf_pkg::THR_RESET; end
			endcase
			apply_setup(rate, thr);
			steady_run = (p == 2);
			if (p == 1) hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// mostly runs long enough for fades to finish, some short glitches
				run = ($urandom_range(4) == 0) ? $urandom_range(1, 3)
					: $urandom_range(8, 160);
				lvl = ~lvl;
				for (int k = 0; k < run && sent < PHASE_ITEMS; k++) begin
					offer_sample(lvl, pick_sample(), pick_sample(), 1'b0, literal);
					sent++;
				end
			end
		end
		steady_run = 1'b0;

		s_tvalid <= 1'b0;
		while (mix_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d samples sent, %0d results checked, %0d fades reached their target",
			samples_sent, results_seen, fades_done);
		$display("over %0d fade rate and threshold settings, incl. a %0d cycle output hold",
			settings_used, HOLD_CYCLES);
		if (errors == 0) begin
			$display("tb_stereo_soft_mute_fader: clean");
		end else begin
			$display("tb_stereo_soft_mute_fader: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/ssmf_pkg.sv
rtl/core/ssmf_mul.sv
rtl/core/stereo_soft_mute_fader.sv
rtl/core/ssmf_chk.sv
verif/tb_stereo_soft_mute_fader.sv
